/* src/fifo_queue_with_search_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the FIFO queue with search
// Clocked property checks that vanish when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define FQS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define FQS_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define FQS_ASSERT(label, clk, rst_n, prop, msg)
`define FQS_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* src/fqs_pkg.sv */
// ----------------------------------------------------------------------------
// FIFO queue with search: shared definitions
// Operation and status codes, field widths and stream packing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fqs_pkg;

	// Operation selected by an input item.
	typedef enum logic [1:0] {
		MODE_ENQ  = 2'd0,
		MODE_DEQ  = 2'd1,
		MODE_SRCH = 2'd2,
		MODE_LIST = 2'd3
	} mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	localparam int DATA_W      = 32;
	localparam int POS_W       = 4;
	localparam int OCC_W       = 5;
	localparam int MAX_RESULTS = 16;

	// Stream widths: output tdata is position, data, occupancy padded to bytes.
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_FIELD_W = POS_W + DATA_W + OCC_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
	localparam int OUT_TUSER_W = 3;

endpackage

`default_nettype wire

/* src/fqs_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wen,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* src/fifo_queue_with_search.sv */
// ----------------------------------------------------------------------------
// FIFO queue with search
// Ring-buffer queue of signed 32-bit values with enqueue, dequeue, search
// and list operations over a stream interface.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH values in a RAM with one registered read
// port, addressed as a ring from a head pointer. Enqueue, and any operation
// on an empty queue, loads its result as soon as the item is accepted.
// Dequeue makes one RAM read of the head entry. Search reads one entry per
// cycle from the head and finishes on the first match or on the last entry.
// List emits one item per cycle while the output side is ready (at most 16
// items are listed). The single RAM read port makes search and list walk the
// queue one entry at a time. The block takes no new item while an operation
// walks the queue. A result register sits on the output; an item is accepted
// in the idle state whenever that register is free or being drained.
`default_nettype none

`include "fifo_queue_with_search_assert.svh"

module fifo_queue_with_search
	import fqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// value[31:0]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// mode[1:0]
	input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// position[3:0], data_out[35:4], occupancy[40:36], zero padding above
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// status[1:0], found[2]
	output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
	output logic                        m_axis_tlast
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t              state_q;
	mode_t               op_q;
	logic [DATA_W-1:0]   key_q;
	logic [CNT_W-1:0]    off_q;
	logic [CNT_W-1:0]    off_d;
	logic [IDX_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;

	logic                m_valid_q;
	status_t             status_q;
	logic                found_q;
	logic [POS_W-1:0]    pos_q;
	logic [DATA_W-1:0]   data_q;
	logic [OCC_W-1:0]    occ_q;
	logic                last_q;

	logic                out_free;
	logic                out_load;
	logic                in_acc;
	mode_t               in_mode;
	logic                full;
	logic                hit;
	logic                end_cnt;
	logic                end_list;
	logic                adv;
	logic                ram_wen;
	logic [IDX_W-1:0]    ram_waddr;
	logic [IDX_W-1:0]    ram_raddr;
	logic [DATA_W-1:0]   ram_rdata;

	// Ring slot of an offset from a base; the sum stays below twice the depth.
	function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] offs);
		logic [SUM_W-1:0] s;
		s = SUM_W'(base) + SUM_W'(offs);
		if (s >= SUM_W'(QUEUE_DEPTH)) begin
			s = s - SUM_W'(QUEUE_DEPTH);
		end
		return IDX_W'(s);
	endfunction

	// Handshake and status decode.
	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_mode       = mode_t'(s_axis_tuser);
	assign full          = (count_q == CNT_W'(QUEUE_DEPTH));
	assign hit           = (ram_rdata == key_q);
	assign end_cnt       = (int'(off_q) + 1 == int'(count_q));
	assign end_list      = end_cnt || (int'(off_q) + 1 == MAX_RESULTS);

	// Walk control: the read address follows the next offset so that the
	// registered read data always belongs to the current offset.
	always_comb begin
		adv = 1'b0;
		if (state_q == ST_WALK) begin
			case (op_q)
				MODE_SRCH: adv = !hit && !end_cnt;
				MODE_LIST: adv = out_free && !end_list;
				default:   adv = 1'b0;
			endcase
		end
		if (state_q == ST_WALK) begin
			off_d = adv ? off_q + CNT_W'(1) : off_q;
		end else begin
			off_d = '0;
		end
	end

	// A new result item enters the output register in this cycle.
	always_comb begin
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: out_load = in_acc && ((in_mode == MODE_ENQ) || (count_q == '0));
			ST_WALK: begin
				case (op_q)
					MODE_SRCH: out_load = (hit || end_cnt) && out_free;
					default:   out_load = out_free;
				endcase
			end
		endcase
	end

	assign ram_raddr = ring_slot(head_q, off_d);
	assign ram_wen   = in_acc && (in_mode == MODE_ENQ) && !full;
	assign ram_waddr = ring_slot(head_q, count_q);

	fqs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.wen   (ram_wen),
		.waddr (ram_waddr),
		.wdata (s_axis_tdata[DATA_W-1:0]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer with queue state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			off_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			off_q <= off_d;
			// The result register loads a new item or keeps one that still waits.
			m_valid_q <= out_load || (m_valid_q && !m_axis_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q     <= in_mode;
						key_q    <= s_axis_tdata[DATA_W-1:0];
						found_q  <= 1'b0;
						pos_q    <= '0;
						data_q   <= '0;
						last_q   <= 1'b1;
						if (in_mode == MODE_ENQ) begin
							if (full) begin
								status_q <= STAT_FULL;
								occ_q    <= OCC_W'(count_q);
							end else begin
								status_q <= STAT_OK;
								count_q  <= count_q + CNT_W'(1);
								occ_q    <= OCC_W'(count_q + CNT_W'(1));
							end
						end else if (count_q == '0) begin
							status_q  <= STAT_EMPTY;
							occ_q     <= '0;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					unique case (op_q)
						MODE_DEQ: begin
							if (out_free) begin
								status_q  <= STAT_OK;
								data_q    <= ram_rdata;
								occ_q     <= OCC_W'(count_q - CNT_W'(1));
								count_q   <= count_q - CNT_W'(1);
								head_q    <= ring_slot(head_q, CNT_W'(1));
								state_q   <= ST_IDLE;
							end
						end
						MODE_SRCH: begin
							if ((hit || end_cnt) && out_free) begin
								status_q  <= STAT_OK;
								found_q   <= hit;
								pos_q     <= hit ? POS_W'(off_q) : '0;
								occ_q     <= OCC_W'(count_q);
								state_q   <= ST_IDLE;
							end
						end
						default: begin
							if (out_free) begin
								status_q  <= STAT_OK;
								pos_q     <= POS_W'(off_q);
								data_q    <= ram_rdata;
								occ_q     <= OCC_W'(count_q);
								last_q    <= end_list;
								if (end_list) begin
									state_q <= ST_IDLE;
								end
							end
						end
					endcase
				end
			endcase
		end
	end

	// Output packing.
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, occ_q, data_q, pos_q};
	assign m_axis_tuser  = {found_q, status_q};
	assign m_axis_tlast  = last_q;

	// The entry count never exceeds the queue depth.
	`FQS_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(QUEUE_DEPTH), "count overflow")

	// An accepted enqueue on a queue that is not full grows the count by one.
	`FQS_ASSERT(a_enq_count, clk, arst_n, (in_acc && in_mode == MODE_ENQ && !full) |=> (count_q == $past(count_q) + CNT_W'(1)), "enqueue count")

	// The head pointer moves only when a dequeue completes.
	`FQS_ASSERT(a_head_move, clk, arst_n, !$stable(head_q) |-> ($past(state_q) == ST_WALK && $past(op_q) == MODE_DEQ), "head moved")

	// A walk never runs on an empty queue.
	`FQS_NEVER(a_walk_empty, clk, arst_n, state_q == ST_WALK && count_q == '0, "walk on empty queue")

endmodule

`default_nettype wire
